// ===== design/hsa_pkg.sv =====
package hsa_pkg;

  localparam int SLOT_COUNT = 8192;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int LINK_W     = IDX_W + 1;
  localparam int IDENT_W    = 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [IDENT_W-1:0] ID_DELETED = IDENT_W'(1);
  localparam logic [IDENT_W-1:0] ID_FIRST   = IDENT_W'(2);
  localparam logic [LINK_W-1:0]  LINK_NONE  = LINK_W'(SLOT_COUNT);

  typedef struct packed {
    logic load;    // request accepted: capture it and read the slot tables
    logic commit;  // update the tables and load the result register
  } hsa_cmd_t;

endpackage

// ===== design/hsa_ctrl.sv =====
module hsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output hsa_pkg::hsa_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.commit = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/hsa_datapath.sv =====
module hsa_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsa_pkg::hsa_cmd_t             cmd,
  input  logic [1:0]                    in_opcode,
  input  logic [hsa_pkg::IDX_W-1:0]     in_slot_index,
  input  logic [hsa_pkg::IDENT_W-1:0]   in_handle_id,
  output logic [hsa_pkg::IDX_W-1:0]     out_granted_index,
  output logic [hsa_pkg::IDENT_W-1:0]   out_granted_id,
  output logic                          out_handle_valid,
  output logic [1:0]                    out_status
);

  logic [hsa_pkg::IDENT_W-1:0] ident_mem [hsa_pkg::SLOT_COUNT];
  logic [hsa_pkg::LINK_W-1:0]  link_mem  [hsa_pkg::SLOT_COUNT];

  logic [hsa_pkg::IDENT_W-1:0] ident_q;
  logic [hsa_pkg::LINK_W-1:0]  link_q;

  logic [1:0]                  op_r;
  logic [hsa_pkg::IDX_W-1:0]   idx_r;
  logic [hsa_pkg::IDENT_W-1:0] id_r;

  // slots at or above fresh_r were never handed out; their table contents are ignored and they read as deleted
  logic [hsa_pkg::LINK_W-1:0]  head_r, head_nxt;
  logic [hsa_pkg::LINK_W-1:0]  fresh_r, fresh_nxt;
  logic [hsa_pkg::IDENT_W-1:0] ctr_r, ctr_nxt;

  logic [hsa_pkg::IDX_W-1:0]   rd_addr;
  logic [hsa_pkg::LINK_W-1:0]  slot_ext;
  logic [hsa_pkg::IDENT_W-1:0] ident_rd;
  logic [hsa_pkg::LINK_W-1:0]  link_rd;
  logic [hsa_pkg::IDENT_W-1:0] ctr_inc;
  logic                        full;
  logic                        match;

  logic                        ident_we;
  logic [hsa_pkg::IDENT_W-1:0] ident_wd;
  logic                        link_we;
  logic [hsa_pkg::IDX_W-1:0]   wr_addr;

  logic [hsa_pkg::IDX_W-1:0]   g_index;
  logic [hsa_pkg::IDENT_W-1:0] g_id;
  logic                        g_valid;
  logic [1:0]                  g_status;

  assign rd_addr = (in_opcode == hsa_pkg::OP_ALLOC) ? head_r[hsa_pkg::IDX_W-1:0]
                                                     : in_slot_index;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      idx_r   <= in_slot_index;
      id_r    <= in_handle_id;
      ident_q <= ident_mem[rd_addr];
    end
    if (ident_we) ident_mem[wr_addr] <= ident_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) link_q <= link_mem[rd_addr];
    if (link_we) link_mem[wr_addr] <= head_r;
  end

  always_comb begin
    slot_ext = (op_r == hsa_pkg::OP_ALLOC) ? head_r : {1'b0, idx_r};
    ident_rd = (slot_ext >= fresh_r) ? hsa_pkg::ID_DELETED : ident_q;
    link_rd  = (head_r >= fresh_r) ? head_r + 1'b1 : link_q;
    full     = (head_r >= hsa_pkg::LINK_NONE);
    match    = ({1'b0, idx_r} < hsa_pkg::LINK_NONE) && (id_r >= hsa_pkg::ID_FIRST) &&
               (ident_rd == id_r);
    ctr_inc  = ctr_r + 1'b1;
  end

  always_comb begin
    head_nxt  = head_r;
    fresh_nxt = fresh_r;
    ctr_nxt   = ctr_r;
    ident_we  = 1'b0;
    ident_wd  = hsa_pkg::ID_DELETED;
    link_we   = 1'b0;
    wr_addr   = idx_r;
    g_index   = '0;
    g_id      = '0;
    g_valid   = 1'b0;
    g_status  = hsa_pkg::ST_OK;
    case (op_r)
      hsa_pkg::OP_ALLOC: begin
        if (full) begin
          g_status = hsa_pkg::ST_FULL;
        end else begin
          wr_addr  = head_r[hsa_pkg::IDX_W-1:0];
          ident_we = cmd.commit;
          ident_wd = ctr_r;
          head_nxt = link_rd;
          if (head_r == fresh_r) fresh_nxt = fresh_r + 1'b1;
          // skip the reserved identifiers on wrap
          ctr_nxt  = (ctr_inc == '0) ? hsa_pkg::ID_FIRST : ctr_inc;
          g_index  = head_r[hsa_pkg::IDX_W-1:0];
          g_id     = ctr_r;
        end
      end
      hsa_pkg::OP_FREE: begin
        if (match) begin
          ident_we = cmd.commit;
          link_we  = cmd.commit;
          head_nxt = {1'b0, idx_r};
        end else begin
          g_status = hsa_pkg::ST_BAD;
        end
      end
      hsa_pkg::OP_CHECK: begin
        g_valid = match;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fresh_r <= '0;
      ctr_r   <= hsa_pkg::ID_FIRST;
    end else if (cmd.commit) begin
      head_r  <= head_nxt;
      fresh_r <= fresh_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted_index <= g_index;
      out_granted_id    <= g_id;
      out_handle_valid  <= g_valid;
      out_status        <= g_status;
    end
  end

`ifndef SYNTH
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= hsa_pkg::LINK_NONE) else $error("free list head out of range");
  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= hsa_pkg::LINK_NONE) else $error("fill count out of range");
  a_ctr_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    ctr_r >= hsa_pkg::ID_FIRST) else $error("identifier counter holds reserved value");
  a_no_load_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit)) else $error("load and commit in the same cycle");
`endif

endmodule

// ===== design/handle_slot_allocator_core.sv =====
// Generational handle table with a linked free list. Each request (allocate,
// free, check) runs in two steps: the accept cycle reads the slot identifier
// and link tables at the addressed slot; the commit step compares, updates the
// tables as the request needs and loads the result register. No new request is
// taken until the previous one commits, set by that read-then-write of the slot
// memories. A new request is accepted while the previous result still waits in
// the output register; a stalled result holds back the commit of the next one.
// There is no clearing pass after reset: a fill count tracks which slots were
// ever handed out, and slots at or above it read as deleted and linked in order.
module handle_slot_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[1:0], slot_index[14:2], handle_id[46:15], pad[47]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // granted_index[12:0], granted_id[44:13],
                                  // handle_valid[45], status[47:46]
);

  hsa_pkg::hsa_cmd_t cmd;

  logic [hsa_pkg::IDX_W-1:0]   granted_index;
  logic [hsa_pkg::IDENT_W-1:0] granted_id;
  logic                        handle_valid;
  logic [1:0]                  status;

  hsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  hsa_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_opcode         (in_tdata[1:0]),
    .in_slot_index     (in_tdata[14:2]),
    .in_handle_id      (in_tdata[46:15]),
    .out_granted_index (granted_index),
    .out_granted_id    (granted_id),
    .out_handle_valid  (handle_valid),
    .out_status        (status)
  );

  assign out_tdata = {status, handle_valid, granted_id, granted_index};

endmodule
